### rtl/quadrature_position_p_drive_macros.svh
// Assertion helpers used by the checker file qpd_checker.sv.
`ifndef QUADRATURE_POSITION_P_DRIVE_MACROS_SVH
`define QUADRATURE_POSITION_P_DRIVE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define QPD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/qpd_pkg.sv
package qpd_pkg;

  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned DutyBits   = 8;

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] CFG_TARGET_POSITION = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_GAIN            = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_MIN_DUTY        = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_MAX_DUTY        = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_STOP_MARGIN     = 3'd4;

  localparam logic [15:0]         GAIN_RESET   = 16'd256;
  localparam logic [DutyBits-1:0] DRIVE_TOP    = 8'd255;
  localparam logic [15:0]         MARGIN_RESET = 16'd1;

  // Drive decision handed from the error stage to the drive stage
  typedef struct packed {
    logic done;
    logic fwd;
    logic rev;
  } dir_t;

  // Gray-coded encoder levels to phase: 00->0, 10->1, 11->2, 01->3 (a,b)
  function automatic logic [1:0] phase_of(input logic a, input logic b);
    phase_of = {b, a ^ b};
  endfunction

endpackage

### rtl/quadrature_position_p_drive.sv
// channel   | handshake                | payload
// ----------+--------------------------+--------------------------------------------
// input     | in_valid_i / in_stall_o  | sensor_a_i, sensor_b_i
// result    | out_valid_o / out_stall_i| position_o, drive_forward_o,
//           |                          | drive_reverse_o, done_res_o
// config    | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low; each item passes through
// registered stages: decode/count, error and multiply, clamp and output register.
// The position count and phase update as the item is taken, so adjacent items
// need no spacing. Reset clears the count and phase and loads register defaults.
// out_stall_i holds the output register and backs up through the stages; the
// input stalls only once every stage holds an item.
module quadrature_position_p_drive #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [qpd_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [15:0]                      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             sensor_a_i,
  input  logic                             sensor_b_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [15:0]                      position_o,
  output logic [7:0]                       drive_forward_o,
  output logic [7:0]                       drive_reverse_o,
  output logic                             done_res_o
);

  localparam int unsigned MagBits  = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam int unsigned ProdBits = MagBits + 16;

  logic [15:0] target_q, gain_q, margin_q;
  logic [7:0]  min_duty_q, max_duty_q;

  logic                     dec_ready, dec_valid;
  logic [POSITION_BITS-1:0] dec_pos;
  logic                     err_ready, err_valid;
  logic [15:0]              err_position;
  logic [ProdBits-1:0]      err_prod;
  qpd_pkg::dir_t            err_dir;
  logic                     drv_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= 16'd0;
      gain_q     <= qpd_pkg::GAIN_RESET;
      min_duty_q <= 8'd0;
      max_duty_q <= qpd_pkg::DRIVE_TOP;
      margin_q   <= qpd_pkg::MARGIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qpd_pkg::CFG_TARGET_POSITION: target_q   <= cfg_data_i;
        qpd_pkg::CFG_GAIN:            gain_q     <= cfg_data_i;
        qpd_pkg::CFG_MIN_DUTY:        min_duty_q <= cfg_data_i[7:0];
        qpd_pkg::CFG_MAX_DUTY:        max_duty_q <= cfg_data_i[7:0];
        qpd_pkg::CFG_STOP_MARGIN:     margin_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = !dec_ready;

  qpd_decoder #(
    .POSITION_BITS(POSITION_BITS)
  ) u_decoder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (dec_ready),
    .sensor_a_i (sensor_a_i),
    .sensor_b_i (sensor_b_i),
    .valid_o    (dec_valid),
    .ready_i    (err_ready),
    .pos_o      (dec_pos)
  );

  qpd_error #(
    .POSITION_BITS(POSITION_BITS)
  ) u_error (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (dec_valid),
    .ready_o           (err_ready),
    .pos_i             (dec_pos),
    .target_position_i (target_q),
    .gain_i            (gain_q),
    .stop_margin_i     (margin_q),
    .valid_o           (err_valid),
    .ready_i           (drv_ready),
    .position_o        (err_position),
    .prod_o            (err_prod),
    .dir_o             (err_dir)
  );

  qpd_drive #(
    .POSITION_BITS(POSITION_BITS)
  ) u_drive (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (err_valid),
    .ready_o         (drv_ready),
    .position_i      (err_position),
    .prod_i          (err_prod),
    .dir_i           (err_dir),
    .min_duty_i      (min_duty_q),
    .max_duty_i      (max_duty_q),
    .valid_o         (out_valid_o),
    .ready_i         (!out_stall_i),
    .position_o      (position_o),
    .drive_forward_o (drive_forward_o),
    .drive_reverse_o (drive_reverse_o),
    .done_res_o      (done_res_o)
  );

endmodule

### rtl/qpd_decoder.sv
module qpd_decoder #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic                     sensor_a_i,
  input  logic                     sensor_b_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [POSITION_BITS-1:0] pos_o
);

  logic [1:0]               phase;
  logic [1:0]               phase_q;
  logic [POSITION_BITS-1:0] count_d, count_q;
  logic                     valid_q;
  logic                     accept;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;
  assign phase   = qpd_pkg::phase_of(sensor_a_i, sensor_b_i);

  always_comb begin
    count_d = count_q;
    if (phase == phase_q + 2'd1) begin
      count_d = count_q + {{(POSITION_BITS-1){1'b0}}, 1'b1};
    end else if (phase == phase_q - 2'd1) begin
      count_d = count_q - {{(POSITION_BITS-1){1'b0}}, 1'b1};
    end
    // same phase or a jump by two leaves the count alone
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase;
        count_q <= count_d;
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign valid_o = valid_q;
  assign pos_o   = count_q;

endmodule

### rtl/qpd_error.sv
module qpd_error #(
  parameter int unsigned POSITION_BITS = 16,
  localparam int unsigned MagBits = (POSITION_BITS > 16) ? POSITION_BITS : 16,
  localparam int unsigned ErrBits = MagBits + 1,
  localparam int unsigned ProdBits = MagBits + 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [POSITION_BITS-1:0] pos_i,
  input  logic [15:0]              target_position_i,
  input  logic [15:0]              gain_i,
  input  logic [15:0]              stop_margin_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [15:0]              position_o,
  output logic [ProdBits-1:0]      prod_o,
  output qpd_pkg::dir_t            dir_o
);

  logic [ErrBits-1:0]         tgt_ext, pos_ext, err;
  logic [ErrBits-1:0]         err_abs;
  logic [MagBits-1:0]         mag;
  logic [POSITION_BITS+15:0]  pos_wide;
  qpd_pkg::dir_t              dir;
  logic                       valid_q;
  logic                       accept;
  logic [15:0]                position_q;
  logic [ProdBits-1:0]        prod_q;
  qpd_pkg::dir_t              dir_q;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  assign tgt_ext = {{(ErrBits-16){target_position_i[15]}}, target_position_i};
  assign pos_ext = {{(ErrBits-POSITION_BITS){pos_i[POSITION_BITS-1]}}, pos_i};
  assign err     = tgt_ext - pos_ext;
  assign err_abs = err[ErrBits-1] ? (~err + {{(ErrBits-1){1'b0}}, 1'b1}) : err;
  assign mag     = err_abs[MagBits-1:0];

  // result carries the raw count, zero-extended or cut to 16 bits
  assign pos_wide = {16'd0, pos_i};

  always_comb begin
    dir.done = ({{(ProdBits-MagBits){1'b0}}, mag} < {{(ProdBits-16){1'b0}}, stop_margin_i});
    dir.fwd  = !dir.done && !err[ErrBits-1] && (err != '0);
    dir.rev  = !dir.done && err[ErrBits-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      position_q <= pos_wide[15:0];
      prod_q     <= ProdBits'(mag) * ProdBits'(gain_i);
      dir_q      <= dir;
    end
  end

  assign valid_o    = valid_q;
  assign position_o = position_q;
  assign prod_o     = prod_q;
  assign dir_o      = dir_q;

endmodule

### rtl/qpd_drive.sv
module qpd_drive #(
  parameter int unsigned POSITION_BITS = 16,
  localparam int unsigned MagBits = (POSITION_BITS > 16) ? POSITION_BITS : 16,
  localparam int unsigned ProdBits = MagBits + 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [15:0]         position_i,
  input  logic [ProdBits-1:0] prod_i,
  input  qpd_pkg::dir_t       dir_i,
  input  logic [7:0]          min_duty_i,
  input  logic [7:0]          max_duty_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [15:0]         position_o,
  output logic [7:0]          drive_forward_o,
  output logic [7:0]          drive_reverse_o,
  output logic                done_res_o
);

  logic [ProdBits-9:0] duty_full;
  logic [7:0]          duty_sat, duty_lo, duty, level;
  logic                valid_q;
  logic                accept;
  logic [15:0]         position_q;
  logic [7:0]          fwd_q, rev_q;
  logic                done_q;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  // Q24.8 product truncated, saturated to 8 bits, clamped to min/max, inverted
  assign duty_full = prod_i[ProdBits-1:8];
  assign duty_sat  = (|duty_full[ProdBits-9:8]) ? 8'hFF : duty_full[7:0];
  assign duty_lo   = (duty_sat < min_duty_i) ? min_duty_i : duty_sat;
  assign duty      = (duty_lo > max_duty_i) ? max_duty_i : duty_lo;
  assign level     = qpd_pkg::DRIVE_TOP - duty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      position_q <= position_i;
      fwd_q      <= dir_i.fwd ? level : 8'd0;
      rev_q      <= dir_i.rev ? level : 8'd0;
      done_q     <= dir_i.done;
    end
  end

  assign valid_o         = valid_q;
  assign position_o      = position_q;
  assign drive_forward_o = fwd_q;
  assign drive_reverse_o = rev_q;
  assign done_res_o      = done_q;

endmodule

### rtl/qpd_checker.sv
`include "quadrature_position_p_drive_macros.svh"

module qpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] drive_forward_o,
  input logic [7:0] drive_reverse_o,
  input logic       done_res_o
);

  `QPD_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o,
                  "result item dropped while stalled")

  `QPD_ASSERT_IMP(a_done_quiet, out_valid_o && done_res_o,
                  drive_forward_o == 8'd0 && drive_reverse_o == 8'd0,
                  "drive active while done")

  `QPD_ASSERT_IMP(a_one_side, out_valid_o,
                  drive_forward_o == 8'd0 || drive_reverse_o == 8'd0,
                  "both drives active")

  // an empty output register never holds off the input side
  `QPD_ASSERT_IMP(a_no_deadlock, !out_valid_o, !in_stall_o,
                  "input stalled with empty output")

endmodule

bind quadrature_position_p_drive qpd_checker u_qpd_checker (.*);
